[hw/rtl/sjss_pkg.sv]
package sjss_pkg;

    // Operation codes carried on the input channel
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_NEEDLE = 2'd1,
        OP_HAY    = 2'd2,
        OP_END    = 2'd3
    } t_op;

    // Commands from the controller to the datapath (at most one set per cycle)
    typedef struct packed {
        logic restart;
        logic load_needle;
        logic take_byte;
        logic finish;
    } t_cmd;

    // Search result as the datapath sees it right now
    typedef struct packed {
        logic        found;
        logic [15:0] char_index;
        logic        needle_overflow;
        logic        too_long;
    } t_result;

    // Shift-JIS lead byte: 0x81-0x9F or 0xE0-0xFC
    function automatic logic is_lead(input logic [7:0] b);
        return ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hFC));
    endfunction

endpackage

[hw/rtl/sjss_in_if.sv]
interface sjss_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

[hw/rtl/sjss_out_if.sv]
interface sjss_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] char_index;
    logic        needle_overflow;
    logic        too_long;

    modport source (output valid, output found, output char_index,
                    output needle_overflow, output too_long, input ready);
    modport sink   (input valid, input found, input char_index,
                    input needle_overflow, input too_long, output ready);
endinterface

[hw/rtl/sjss_datapath.sv]
module sjss_datapath
    import sjss_pkg::*;
#(
    parameter int              NEEDLE_MAX = 32,
    parameter longint unsigned MAX_CHARS  = 65535
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_data_byte,
    output t_result    o_status
);

    localparam int LW  = $clog2(NEEDLE_MAX + 1);
    localparam int IXW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int CW  = $clog2(MAX_CHARS + 1);
    localparam logic [CW-1:0] MAXC = MAX_CHARS[CW-1:0];
    localparam logic [LW-1:0] NMAX = LW'(NEEDLE_MAX);

    // Needle kept newest-first so entry j lines up with window entry j
    logic [7:0]    r_needle [NEEDLE_MAX];
    logic [7:0]    n_needle [NEEDLE_MAX];
    logic [LW-1:0] r_len, n_len;
    logic          r_ovf, n_ovf;

    // Haystack window, newest byte at entry 0
    logic [7:0]            r_win_byte [NEEDLE_MAX];
    logic [7:0]            n_win_byte [NEEDLE_MAX];
    logic [15:0]           r_win_idx  [NEEDLE_MAX];
    logic [15:0]           n_win_idx  [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] r_win_start, n_win_start;

    logic          r_trail, n_trail;
    logic [CW-1:0] r_cc, n_cc;
    logic [LW-1:0] r_seen, n_seen;
    logic          r_mfound, n_mfound;
    logic [15:0]   r_midx, n_midx;
    logic          r_too_long, n_too_long;

    // Incoming haystack byte: start bit, clamped character index
    logic                  hs_start;
    logic [CW+15:0]        cc_ext;
    logic [15:0]           hs_idx;
    logic [7:0]            w_byte  [NEEDLE_MAX];
    logic [15:0]           w_idx   [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] w_start;
    logic [NEEDLE_MAX-1:0] hit;
    logic [LW-1:0]         seen_next;
    logic [LW-1:0]         len_m1;
    logic [IXW-1:0]        pos;
    logic                  match_now;

    assign hs_start  = !r_trail;
    assign cc_ext    = {16'b0, r_cc};
    assign hs_idx    = (|cc_ext[CW+15:16]) ? 16'hFFFF : cc_ext[15:0];
    assign seen_next = (r_seen == NMAX) ? r_seen : r_seen + LW'(1);
    assign len_m1    = r_len - LW'(1);
    assign pos       = len_m1[IXW-1:0];

    // Window after the shift, and the per-entry compare against the needle
    always_comb begin
        w_byte[0]  = i_data_byte;
        w_idx[0]   = hs_idx;
        w_start[0] = hs_start;
        for (int j = 1; j < NEEDLE_MAX; j++) begin
            w_byte[j]  = r_win_byte[j-1];
            w_idx[j]   = r_win_idx[j-1];
            w_start[j] = r_win_start[j-1];
        end
        for (int j = 0; j < NEEDLE_MAX; j++) begin
            hit[j] = (LW'(j) >= r_len) || (w_byte[j] == r_needle[j]);
        end
    end

    assign match_now = !r_mfound && (r_len != '0) && (seen_next >= r_len) &&
                       w_start[pos] && (&hit);

    // Next-state logic for all commands
    always_comb begin
        n_needle    = r_needle;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_win_byte  = r_win_byte;
        n_win_idx   = r_win_idx;
        n_win_start = r_win_start;
        n_trail     = r_trail;
        n_cc        = r_cc;
        n_seen      = r_seen;
        n_mfound    = r_mfound;
        n_midx      = r_midx;
        n_too_long  = r_too_long;

        if (i_cmd.restart || i_cmd.finish) begin
            n_trail    = 1'b0;
            n_cc       = '0;
            n_seen     = '0;
            n_mfound   = 1'b0;
            n_too_long = 1'b0;
        end
        if (i_cmd.restart) begin
            n_len = '0;
            n_ovf = 1'b0;
        end

        // Append needle byte, or flag overflow once the store is full
        if (i_cmd.load_needle) begin
            if (r_len != NMAX) begin
                n_needle[0] = i_data_byte;
                for (int j = 1; j < NEEDLE_MAX; j++) begin
                    n_needle[j] = r_needle[j-1];
                end
                n_len = r_len + LW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end

        // Haystack byte: character tracking, window shift, match check
        if (i_cmd.take_byte) begin
            if (hs_start) begin
                if (r_cc == MAXC) begin
                    n_too_long = 1'b1;
                end else begin
                    n_cc = r_cc + CW'(1);
                end
                n_trail = is_lead(i_data_byte);
            end else begin
                n_trail = 1'b0;
            end
            n_win_byte  = w_byte;
            n_win_idx   = w_idx;
            n_win_start = w_start;
            n_seen      = seen_next;
            if (match_now) begin
                n_mfound = 1'b1;
                n_midx   = w_idx[pos];
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_ovf      <= 1'b0;
            r_trail    <= 1'b0;
            r_cc       <= '0;
            r_seen     <= '0;
            r_mfound   <= 1'b0;
            r_too_long <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_ovf      <= n_ovf;
            r_trail    <= n_trail;
            r_cc       <= n_cc;
            r_seen     <= n_seen;
            r_mfound   <= n_mfound;
            r_too_long <= n_too_long;
        end
    end

    // Payload storage; only entries covered by length and byte count are read
    always_ff @(posedge i_clk) begin
        r_needle    <= n_needle;
        r_win_byte  <= n_win_byte;
        r_win_idx   <= n_win_idx;
        r_win_start <= n_win_start;
        r_midx      <= n_midx;
    end

    // Current result; an empty needle matches any non-empty haystack at 0
    always_comb begin
        o_status.needle_overflow = r_ovf;
        o_status.too_long        = r_too_long;
        o_status.found           = 1'b0;
        o_status.char_index      = 16'd0;
        if (!r_ovf) begin
            if (r_len == '0) begin
                o_status.found = (r_seen != '0);
            end else if (r_mfound) begin
                o_status.found      = 1'b1;
                o_status.char_index = r_midx;
            end
        end
    end

endmodule

[hw/rtl/sjss_ctrl.sv]
module sjss_ctrl
    import sjss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_op,
    output logic       o_in_ready,
    output t_cmd       o_cmd,
    input  t_result    i_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_result    o_out_result
);

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } t_state;

    t_state  r_state;
    t_result r_result;
    t_op     op;
    logic    slot_free;
    logic    accept;

    assign op         = t_op'(i_in_op);
    assign slot_free  = (r_state == ST_EMPTY) || i_out_ready;
    // Only the end item needs room in the result register
    assign o_in_ready = (op != OP_END) || slot_free;
    assign accept     = i_in_valid && o_in_ready;

    // Decode the accepted item into a datapath command
    always_comb begin
        o_cmd = '0;
        if (accept) begin
            case (op)
                OP_START:  o_cmd.restart     = 1'b1;
                OP_NEEDLE: o_cmd.load_needle = 1'b1;
                OP_HAY:    o_cmd.take_byte   = 1'b1;
                OP_END:    o_cmd.finish      = 1'b1;
                default:   o_cmd = '0;
            endcase
        end
    end

    // Result slot state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            if (accept && (op == OP_END)) begin
                r_state  <= ST_FULL;
                r_result <= i_status;
            end else if (i_out_ready) begin
                r_state <= ST_EMPTY;
            end
        end
    end

    assign o_out_valid  = (r_state == ST_FULL);
    assign o_out_result = r_result;

endmodule

[hw/rtl/sjis_aligned_substring_search_unit.sv]
// The result of an end-of-haystack item is registered and valid the cycle after its transfer.
// One item per cycle unless stalled; the compare over all needle entries is combinational.
// An end item stalls only while the previous result is held and not taken.
// Reset (synchronous, active low) clears needle length, overflow, counters, match
// state and the result slot; needle and window contents are not cleared.
module sjis_aligned_substring_search_unit
    import sjss_pkg::*;
#(
    parameter int              NEEDLE_MAX = 32,
    parameter longint unsigned MAX_CHARS  = 65535
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sjss_in_if.sink          i_in,
    sjss_out_if.source       o_out
);

    t_cmd    cmd;
    t_result status;
    t_result out_result;

    sjss_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_op      (i_in.operation),
        .o_in_ready   (i_in.ready),
        .o_cmd        (cmd),
        .i_status     (status),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_result (out_result)
    );

    sjss_datapath #(
        .NEEDLE_MAX (NEEDLE_MAX),
        .MAX_CHARS  (MAX_CHARS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_in.data_byte),
        .o_status    (status)
    );

    assign o_out.found           = out_result.found;
    assign o_out.char_index      = out_result.char_index;
    assign o_out.needle_overflow = out_result.needle_overflow;
    assign o_out.too_long        = out_result.too_long;

endmodule

[hw/rtl/sjss_checker.sv]
module sjss_checker
    import sjss_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_operation,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_found,
    input logic [15:0] i_out_char_index,
    input logic        i_out_needle_overflow
);

    // A held result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    // Index is zero whenever nothing was found
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_char_index == 16'd0)
        else $error("nonzero index without a match");

    // An overflowed needle never reports a match
    a_ovf_nofind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_needle_overflow |-> !i_out_found)
        else $error("match reported with needle overflow");

    // A new result follows only an end-of-haystack transfer
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |->
            $past(i_in_valid && i_in_ready && (i_in_operation == OP_END)))
        else $error("result without end-of-haystack transfer");

endmodule

bind sjis_aligned_substring_search_unit sjss_checker u_sjss_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_valid            (i_in.valid),
    .i_in_ready            (i_in.ready),
    .i_in_operation        (i_in.operation),
    .i_out_valid           (o_out.valid),
    .i_out_ready           (o_out.ready),
    .i_out_found           (o_out.found),
    .i_out_char_index      (o_out.char_index),
    .i_out_needle_overflow (o_out.needle_overflow)
);

[tb/sjis_aligned_substring_search_unit_tb.sv]
module sjis_aligned_substring_search_unit_tb;
    import sjss_pkg::*;

    localparam int          NEEDLE_MAX   = 32;
    localparam int unsigned MAX_CHARS    = 65535;
    localparam int          RANDOM_ITEMS = 1400;
    // Slowest run: ~1.5k items with full gaps plus held results and drains, several times over
    localparam int          CYCLE_LIMIT  = 60_000;

    // Sender pacing for a stretch of items
    typedef enum int {
        GAP_FULL,
        GAP_NONE,
        GAP_SPARSE
    } t_gap_mode;

    typedef struct {
        t_op         op;
        logic [7:0]  data;
        int unsigned gap;
        bit          drain;
    } t_item;

    // Byte mix: zero, ASCII, lead-range edges, non-lead neighbors, 0xFF
    localparam logic [7:0] BYTE_PICKS [12] = '{
        8'h00, 8'h41, 8'h42, 8'h80, 8'h81, 8'h9F,
        8'hA0, 8'hDF, 8'hE0, 8'hFC, 8'hFD, 8'hFF
    };

    logic i_clk;
    logic i_rst_n;

    sjss_in_if  in_bus ();
    sjss_out_if out_bus ();

    sjis_aligned_substring_search_unit #(
        .NEEDLE_MAX(NEEDLE_MAX),
        .MAX_CHARS (MAX_CHARS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    // Pending stimulus and expected search results
    t_item       stim_q[$];
    t_result     pending_results[$];
    logic [7:0]  gen_needle[$];
    t_gap_mode   gap_mode;
    bit          hold_next;
    int unsigned predicted_cnt;
    int unsigned checked_cnt;
    int unsigned err_cnt;
    int unsigned gap_cnt;
    int unsigned stall_cnt;
    int unsigned cycle_cnt;
    t_item       cur;

    // Search state mirror
    logic [7:0]  ndl_mem [NEEDLE_MAX];
    int unsigned ndl_len;
    bit          ndl_ovf;
    logic [7:0]  win_byte [NEEDLE_MAX];
    bit          win_start [NEEDLE_MAX];
    logic [15:0] win_char [NEEDLE_MAX];
    bit          in_trail;
    int unsigned char_cnt;
    int unsigned hay_cnt;
    bit          hit;
    logic [15:0] hit_char;
    bit          char_sat;

    function automatic bit lead_byte(input logic [7:0] b);
        return (b inside {[8'h81:8'h9F]}) || (b inside {[8'hE0:8'hFC]});
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r < 12) begin
            return BYTE_PICKS[r];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic clear_haystack();
        for (int k = 0; k < NEEDLE_MAX; k++) begin
            win_byte[k]  = '0;
            win_start[k] = 1'b0;
            win_char[k]  = '0;
        end
        in_trail = 1'b0;
        char_cnt = 0;
        hay_cnt  = 0;
        hit      = 1'b0;
        hit_char = '0;
        char_sat = 1'b0;
    endtask

    task automatic reset_search_model();
        for (int k = 0; k < NEEDLE_MAX; k++) begin
            ndl_mem[k] = '0;
        end
        ndl_len = 0;
        ndl_ovf = 1'b0;
        clear_haystack();
    endtask

    // Advance the mirror by one accepted item; an end item queues its result
    task automatic sjis_search_step(input logic [1:0] op, input logic [7:0] b);
        t_result     res;
        bit          starts;
        int unsigned ci;
        bit          same;
        case (op)
            OP_START: begin
                reset_search_model();
            end
            OP_NEEDLE: begin
                if (ndl_len < NEEDLE_MAX) begin
                    ndl_mem[ndl_len] = b;
                    ndl_len++;
                end else begin
                    ndl_ovf = 1'b1;
                end
            end
            OP_HAY: begin
                starts = !in_trail;
                ci     = 0;
                if (starts) begin
                    ci = char_cnt;
                    if (char_cnt >= MAX_CHARS) begin
                        char_sat = 1'b1;
                    end else begin
                        char_cnt++;
                    end
                    in_trail = lead_byte(b);
                end else begin
                    in_trail = 1'b0;
                end
                if (ci > 32'hFFFF) begin
                    ci = 32'hFFFF;
                end
                // newest byte at position 0
                for (int k = NEEDLE_MAX - 1; k > 0; k--) begin
                    win_byte[k]  = win_byte[k - 1];
                    win_start[k] = win_start[k - 1];
                    win_char[k]  = win_char[k - 1];
                end
                win_byte[0]  = b;
                win_start[0] = starts;
                win_char[0]  = 16'(ci);
                if (hay_cnt < 32'h1FFFF) begin
                    hay_cnt++;
                end
                // match only if it begins on a character start
                if (!hit && ndl_len > 0 && ndl_len <= NEEDLE_MAX && hay_cnt >= ndl_len
                        && win_start[ndl_len - 1]) begin
                    same = 1'b1;
                    for (int k = 0; k < ndl_len; k++) begin
                        if (win_byte[ndl_len - 1 - k] != ndl_mem[k]) begin
                            same = 1'b0;
                        end
                    end
                    if (same) begin
                        hit      = 1'b1;
                        hit_char = win_char[ndl_len - 1];
                    end
                end
            end
            default: begin
                res = '0;
                if (!ndl_ovf) begin
                    if (ndl_len == 0) begin
                        res.found = (hay_cnt > 0);
                    end else if (hit) begin
                        res.found      = 1'b1;
                        res.char_index = hit_char;
                    end
                end
                res.needle_overflow = ndl_ovf;
                res.too_long        = char_sat;
                pending_results.push_back(res);
                predicted_cnt++;
                clear_haystack();
            end
        endcase
    endtask

    task automatic queue_item(input t_op op, input logic [7:0] b);
        t_item it;
        it.op   = op;
        it.data = b;
        case (gap_mode)
            GAP_NONE:   it.gap = 0;
            GAP_SPARSE: it.gap = ($urandom_range(0, 31) == 0) ? $urandom_range(1, 3) : 0;
            default:    it.gap = $urandom_range(0, 3);
        endcase
        it.drain  = hold_next;
        hold_next = 1'b0;
        stim_q.push_back(it);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Input driver: one transfer per handshake, gaps from the item
    always @(posedge i_clk) begin : drive_proc
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_bus.ready) begin
            if (in_bus.valid) begin
                sjis_search_step(in_bus.operation, in_bus.data_byte);
            end
            if (stim_q.size() == 0) begin
                in_bus.valid <= 1'b0;
            end else if (gap_cnt < stim_q[0].gap) begin
                gap_cnt++;
                in_bus.valid <= 1'b0;
            end else if (stim_q[0].drain && predicted_cnt != checked_cnt) begin
                // hold off until every result is back
                in_bus.valid <= 1'b0;
            end else begin
                cur = stim_q.pop_front();
                gap_cnt = 0;
                in_bus.valid     <= 1'b1;
                in_bus.operation <= cur.op;
                in_bus.data_byte <= cur.data;
            end
        end
    end

    // Result monitor with random backpressure
    always @(posedge i_clk) begin : check_proc
        t_result want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    err_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (out_bus.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, out_bus.found);
                        err_cnt++;
                    end
                    if (out_bus.char_index !== want.char_index) begin
                        $error("char_index: expected %0d, got %0d",
                               want.char_index, out_bus.char_index);
                        err_cnt++;
                    end
                    if (out_bus.needle_overflow !== want.needle_overflow) begin
                        $error("needle_overflow: expected %0d, got %0d",
                               want.needle_overflow, out_bus.needle_overflow);
                        err_cnt++;
                    end
                    if (out_bus.too_long !== want.too_long) begin
                        $error("too_long: expected %0d, got %0d",
                               want.too_long, out_bus.too_long);
                        err_cnt++;
                    end
                end
                checked_cnt <= checked_cnt + 1;
                // every 64 results, a run of 16 without stalls
                stall_cnt = ((checked_cnt % 64) < 16) ? 0 : $urandom_range(0, 3);
            end else if (stall_cnt > 0) begin
                stall_cnt--;
            end
            out_bus.ready <= (stall_cnt == 0);
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic [7:0] hay[$];
        int         rand_cnt;
        int         mark;
        int         nlen;
        int         hlen;
        int         pos;
        int         r;
        t_op        op;

        in_bus.valid     = 1'b0;
        in_bus.operation = OP_START;
        in_bus.data_byte = '0;
        out_bus.ready    = 1'b0;
        i_rst_n          = 1'b0;
        predicted_cnt    = 0;
        checked_cnt      = 0;
        err_cnt          = 0;
        gap_cnt          = 0;
        stall_cnt        = 0;
        cycle_cnt        = 0;
        hold_next        = 1'b0;
        gap_mode         = GAP_FULL;
        reset_search_model();

        // empty needle, empty haystack: not found
        queue_item(OP_START, 8'hFF);
        queue_item(OP_END, 8'h00);
        // empty needle, one zero byte: found at 0
        queue_item(OP_START, 8'h00);
        queue_item(OP_HAY, 8'h00);
        queue_item(OP_END, 8'hFF);
        // needle 82 A0: first copy sits on a trail byte, second is aligned at char 2
        hold_next = 1'b1;
        queue_item(OP_START, 8'h55);
        queue_item(OP_NEEDLE, 8'h82);
        queue_item(OP_NEEDLE, 8'hA0);
        queue_item(OP_HAY, 8'h82);
        queue_item(OP_HAY, 8'h82);
        queue_item(OP_HAY, 8'hA0);
        queue_item(OP_HAY, 8'h82);
        queue_item(OP_HAY, 8'hA0);
        queue_item(OP_END, 8'hAA);
        // same needle searched again, first with nothing, then with a miss
        queue_item(OP_END, 8'h0F);
        queue_item(OP_HAY, 8'hFF);
        queue_item(OP_END, 8'hF0);
        // zero needle byte after an FC lead: trail zero skipped, next zero at char 1
        queue_item(OP_START, 8'h00);
        queue_item(OP_NEEDLE, 8'h00);
        queue_item(OP_HAY, 8'hFC);
        queue_item(OP_HAY, 8'h00);
        queue_item(OP_HAY, 8'h00);
        queue_item(OP_END, 8'h3C);
        gen_needle = '{8'h00};

        // Random searches: mostly whole runs with a planted needle, some noise
        rand_cnt = 0;
        while (rand_cnt < RANDOM_ITEMS) begin
            mark      = stim_q.size();
            r         = $urandom_range(0, 4);
            gap_mode  = (r == 0) ? GAP_NONE : ((r == 1) ? GAP_SPARSE : GAP_FULL);
            hold_next = ($urandom_range(0, 11) == 0);
            if (gen_needle.size() == 0 || $urandom_range(0, 4) != 0) begin
                queue_item(OP_START, 8'($urandom_range(0, 255)));
                gen_needle.delete();
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    nlen = 0;
                end else if (r < 15) begin
                    nlen = $urandom_range(1, 4);
                end else if (r < 18) begin
                    nlen = $urandom_range(5, NEEDLE_MAX - 1);
                end else if (r == 18) begin
                    nlen = NEEDLE_MAX;
                end else begin
                    nlen = $urandom_range(NEEDLE_MAX + 1, NEEDLE_MAX + 3);
                end
                repeat (nlen) begin
                    gen_needle.push_back(pick_byte());
                    queue_item(OP_NEEDLE, gen_needle[$]);
                end
            end
            hay.delete();
            hlen = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
            repeat (hlen) begin
                hay.push_back(pick_byte());
            end
            if (gen_needle.size() > 0 && gen_needle.size() <= NEEDLE_MAX
                    && $urandom_range(0, 9) < 7) begin
                pos = $urandom_range(0, hay.size());
                for (int k = gen_needle.size() - 1; k >= 0; k--) begin
                    hay.insert(pos, gen_needle[k]);
                end
            end
            foreach (hay[k]) begin
                r = $urandom_range(0, 59);
                if (r == 0) begin
                    // needle grows in the middle of the haystack
                    gen_needle.push_back(pick_byte());
                    queue_item(OP_NEEDLE, gen_needle[$]);
                end else if (r == 1) begin
                    op = t_op'($urandom_range(0, 3));
                    queue_item(op, 8'($urandom_range(0, 255)));
                    if (op == OP_START) begin
                        gen_needle.delete();
                    end else if (op == OP_NEEDLE) begin
                        gen_needle.push_back(stim_q[$].data);
                    end
                end
                queue_item(OP_HAY, hay[k]);
            end
            queue_item(OP_END, 8'($urandom_range(0, 255)));
            rand_cnt += stim_q.size() - mark;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || in_bus.valid || predicted_cnt != checked_cnt) begin
            @(negedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
